// ----- src/mpld_pkg.sv -----
// Shared constants for the midpoint-to-line distance block.
`timescale 1ns / 1ps
package mpld_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OUT_BITS       = 25;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int FIFO_DEPTH     = 4;
endpackage

// ----- src/midpoint_to_line_distance.sv -----
// Top level: distance from a segment midpoint to a reference line.
// Path with an empty queue: front register, queue, 3 product stages, start register, 25 root steps.
// Throughput: one word per cycle; the back pipeline stalls as a whole on out_tready.
// The front stage and a 4-entry queue keep taking words while the back side stalls.
// Reset: synchronous active-low rst_n clears valid flags, queue pointers and the queue count only.
`timescale 1ns / 1ps
module midpoint_to_line_distance #(
  parameter int COORD_BITS = mpld_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mpld_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((8 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = mpld_pkg::OUT_TDATA_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // distance_q8
  output logic [OUT_W-1:0] out_tdata,
  // degenerate
  output logic             out_tuser
);
  localparam int CB = COORD_BITS;
  localparam int FW = 2 * (CB + 1) + 6 * CB + 1;
  localparam int OB = mpld_pkg::OUT_BITS;

  logic          f_valid, f_ready, q_valid, q_ready, q_full;
  logic [FW-1:0] f_data, q_data;
  logic [OB-1:0] dist_w;

  mpld_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata[8*CB-1:0]),
    .f_valid(f_valid), .f_ready(f_ready), .f_data(f_data)
  );

  mpld_fifo #(.W(FW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data),
    .full(q_full)
  );

  mpld_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .b_valid(q_valid), .b_ready(q_ready), .b_data(q_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_dist(dist_w), .out_deg(out_tuser)
  );

  assign out_tdata = OUT_W'(dist_w);

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> dist_w == '0)
    else $error("degenerate word with nonzero distance");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && f_valid |-> !f_ready)
    else $error("queue accepted a word while full");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(dist_w))
    else $error("back pipeline moved during output stall");
endmodule

// ----- src/mpld_front.sv -----
// Front stage: midpoint, line coefficients A and B, degenerate check.
`timescale 1ns / 1ps
module mpld_front #(
  parameter int COORD_BITS = mpld_pkg::COORD_BITS_DEF,
  localparam int CB = COORD_BITS,
  localparam int FW = 2 * (CB + 1) + 6 * CB + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [8*CB-1:0] in_data,
  output logic          f_valid,
  input  logic          f_ready,
  output logic [FW-1:0] f_data
);
  logic signed [CB-1:0] ax, ay, bx, by, x1, y1, x2, y2;
  logic signed [CB:0]   sx, sy, a, b;
  logic signed [CB:0]   hx, hy;
  logic                 deg;
  logic                 v_r;
  logic [FW-1:0]        d_r;

  assign ax = in_data[0*CB +: CB];
  assign ay = in_data[1*CB +: CB];
  assign bx = in_data[2*CB +: CB];
  assign by = in_data[3*CB +: CB];
  assign x1 = in_data[4*CB +: CB];
  assign y1 = in_data[5*CB +: CB];
  assign x2 = in_data[6*CB +: CB];
  assign y2 = in_data[7*CB +: CB];

  always_comb begin
    sx  = (CB+1)'(ax) + (CB+1)'(bx);
    sy  = (CB+1)'(ay) + (CB+1)'(by);
    // halve with truncation toward zero
    hx  = (sx + (CB+1)'(sx[CB])) >>> 1;
    hy  = (sy + (CB+1)'(sy[CB])) >>> 1;
    a   = (CB+1)'(y2) - (CB+1)'(y1);
    b   = (CB+1)'(x1) - (CB+1)'(x2);
    deg = (a == '0) && (b == '0);
  end

  assign in_ready = !v_r || f_ready;
  assign f_valid  = v_r;
  assign f_data   = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      d_r <= {deg, y2, x2, y1, x1, hy[CB-1:0], hx[CB-1:0], b, a};
    end
  end
endmodule

// ----- src/mpld_fifo.sv -----
// Short word queue between the front and back parts.
`timescale 1ns / 1ps
module mpld_fifo #(
  parameter int W = 8,
  localparam int DEPTH = mpld_pkg::FIFO_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data,
  output logic         full
);
  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign wr_ready = !full;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign push     = wr_valid && !full;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      mem[wp_r] <= wr_data;
    end
  end
endmodule

// ----- src/mpld_back.sv -----
// Back pipeline: products, N and D, N squared, bit-per-stage root search.
`timescale 1ns / 1ps
module mpld_back #(
  parameter int COORD_BITS = mpld_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mpld_pkg::FRAC_BITS_DEF,
  localparam int CB = COORD_BITS,
  localparam int FW = 2 * (CB + 1) + 6 * CB + 1,
  localparam int OB = mpld_pkg::OUT_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          b_valid,
  output logic          b_ready,
  input  logic [FW-1:0] b_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OB-1:0] out_dist,
  output logic          out_deg
);
  localparam int NW  = 2 * CB + 3;
  localparam int DW  = 2 * CB + 3;
  localparam int H   = (NW + 1) / 2;
  localparam int HH  = NW - H;
  localparam int XW  = 2 * NW + 2 * FRAC_BITS;
  localparam int TW  = DW + 2 * OB + 1;
  localparam int WW  = ((XW > TW) ? XW : TW) + 1;

  logic en;

  logic signed [CB:0]   a, b;
  logic signed [CB-1:0] px, py, x1, y1, x2, y2;
  logic                 deg_in;

  assign {deg_in, y2, x2, y1, x1, py, px, b, a} = b_data;

  // stage 1: products
  logic                 v1_r, g1_r;
  logic signed [2*CB:0]   ap_r, bp_r;
  logic signed [2*CB-1:0] c1_r, c2_r;
  logic signed [2*CB+1:0] aa_r, bb_r;

  // stage 2: N and D
  logic                 v2_r, g2_r;
  logic [NW-1:0]        na_r;
  logic [DW-1:0]        d2_r;
  logic signed [NW-1:0] n_s;

  // stage 3: partial products of N squared
  logic                 v3_r, g3_r;
  logic [DW-1:0]        d3_r;
  logic [2*HH-1:0]      phh_r;
  logic [HH+H-1:0]      phl_r;
  logic [2*H-1:0]       pll_r;

  // root search stages; entry 0 is the start value
  logic          sv_r [OB+1];
  logic          sg_r [OB+1];
  logic [WW-1:0] sr_r [OB+1];
  logic [WW-1:0] st_r [OB+1];
  logic [DW-1:0] sd_r [OB+1];
  logic [OB-1:0] sq_r [OB+1];

  assign en      = !sv_r[OB] || out_ready;
  assign b_ready = en;

  always_comb begin
    n_s = NW'(ap_r) + NW'(bp_r) + NW'(c1_r) - NW'(c2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      sv_r[0]  <= 1'b0;
    end else if (en) begin
      v1_r     <= b_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      sv_r[0]  <= v3_r;
    end
    if (en) begin
      g1_r  <= deg_in;
      ap_r  <= a * px;
      bp_r  <= b * py;
      c1_r  <= x2 * y1;
      c2_r  <= x1 * y2;
      aa_r  <= a * a;
      bb_r  <= b * b;
      g2_r  <= g1_r;
      na_r  <= n_s[NW-1] ? NW'(-n_s) : NW'(n_s);
      d2_r  <= DW'(aa_r) + DW'(bb_r);
      g3_r  <= g2_r;
      d3_r  <= d2_r;
      phh_r <= na_r[NW-1:H] * na_r[NW-1:H];
      phl_r <= na_r[NW-1:H] * na_r[H-1:0];
      pll_r <= na_r[H-1:0] * na_r[H-1:0];
      sg_r[0] <= g3_r;
      sd_r[0] <= d3_r;
      sr_r[0] <= ((WW'(phh_r) << (2 * H)) + (WW'(phl_r) << (H + 1)) + WW'(pll_r))
                 << (2 * FRAC_BITS);
      st_r[0] <= '0;
      sq_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < OB; k++) begin : g_step
    localparam int BIT = OB - 1 - k;
    logic [WW-1:0] inc;
    logic          take;
    always_comb begin
      inc  = (st_r[k] << (BIT + 1)) + (WW'(sd_r[k]) << (2 * BIT));
      take = (inc <= sr_r[k]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
      if (en) begin
        sg_r[k+1] <= sg_r[k];
        sd_r[k+1] <= sd_r[k];
        sr_r[k+1] <= take ? sr_r[k] - inc : sr_r[k];
        st_r[k+1] <= take ? st_r[k] + (WW'(sd_r[k]) << BIT) : st_r[k];
        sq_r[k+1] <= take ? (sq_r[k] | (OB'(1) << BIT)) : sq_r[k];
      end
    end
  end

  assign out_valid = sv_r[OB];
  assign out_deg   = sg_r[OB];
  assign out_dist  = sg_r[OB] ? '0 : sq_r[OB];
endmodule
